// File: hw/rtl/cal_pkg.sv
// cal_pkg: shared types and codes for the cursor array list unit
// used by cal_cell, cursor_array_list_unit and cal_checker; no dependencies
package cal_pkg;

  typedef enum logic [3:0] {
    ACT_READ_CUR   = 4'd0,
    ACT_WRITE_CUR  = 4'd1,
    ACT_PREV       = 4'd2,
    ACT_NEXT       = 4'd3,
    ACT_FIRST      = 4'd4,
    ACT_LAST       = 4'd5,
    ACT_DELETE     = 4'd6,
    ACT_INS_BEFORE = 4'd7,
    ACT_INS_AFTER  = 4'd8,
    ACT_READ_IDX   = 4'd9,
    ACT_WRITE_IDX  = 4'd10
  } action_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_RANGE = 2'd2,
    ST_FULL  = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_WRITE,
    CELL_INSERT,
    CELL_DELETE
  } cell_op_t;

endpackage

// File: hw/rtl/cal_cell.sv
// cal_cell: one list slot; holds a word, takes a neighbor's word on insert or delete
// depends on cal_pkg for the cell operation codes
module cal_cell import cal_pkg::*; #(
  parameter int DATA_WIDTH = 32,
  parameter int POS_W      = 6,
  parameter int POS        = 0
) (
  input  logic                  clk,
  input  cell_op_t              op,
  input  logic [POS_W-1:0]      at,
  input  logic [DATA_WIDTH-1:0] wdata,
  input  logic [DATA_WIDTH-1:0] from_lo,
  input  logic [DATA_WIDTH-1:0] from_hi,
  input  logic [POS_W-1:0]      rd_pos,
  output logic [DATA_WIDTH-1:0] word,
  output logic [DATA_WIDTH-1:0] rd_word
);

  localparam logic [POS_W-1:0] ME = POS_W'(POS);

  always_ff @(posedge clk) begin
    case (op)
      CELL_WRITE: begin
        if (at == ME) word <= wdata;
      end
      CELL_INSERT: begin
        if (at == ME) word <= wdata;
        else if (ME > at) word <= from_lo;
      end
      CELL_DELETE: begin
        if (ME >= at) word <= from_hi;
      end
      default: begin
      end
    endcase
  end

  assign rd_word = (rd_pos == ME) ? word : '0;

endmodule

// File: hw/rtl/cursor_array_list_unit.sv
// cursor_array_list_unit: ordered list with cursor built as a row of cal_cell slots
// depends on cal_pkg and cal_cell
//
//  channel | signals                                   | direction
//  in      | in_valid, in_stall, action, value, index  | item in
//  out     | out_valid, out_stall, data, moved,         | result out
//          | status, count, cursor                      |
//
// slots from the target position upward shift together on insert and delete
// the result appears in the output register in the cycle after the beat is accepted
// a new beat is taken in the same cycle the held result leaves
// synchronous reset empties the list and clears the cursor; slot words are not cleared
// out_stall backs up into in_stall only while a result is held
module cursor_array_list_unit import cal_pkg::*; #(
  parameter int CAPACITY   = 64,
  parameter int DATA_WIDTH = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [3:0]         action,
  input  logic signed [31:0] value,
  input  logic [5:0]         index,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] data,
  output logic               moved,
  output logic [1:0]         status,
  output logic [6:0]         count,
  output logic [5:0]         cursor
);

  localparam int PW  = $clog2(CAPACITY);
  localparam int CW  = $clog2(CAPACITY + 1);
  localparam int IW  = (CW > 6) ? CW : 6;
  localparam int EW  = (DATA_WIDTH > 32) ? DATA_WIDTH : 32;
  localparam int OW  = (CW > 7) ? CW : 7;
  localparam int PXW = (PW > 6) ? PW : 6;
  localparam logic [CW-1:0] CAP_CNT = CW'(CAPACITY);

  logic [PW-1:0] cur, cur_next;
  logic [CW-1:0] cnt, cnt_next;

  logic                  accept;
  logic                  empty;
  logic                  idx_ok;
  logic [IW-1:0]         idx_w;
  logic [EW-1:0]         val_ext;
  logic [DATA_WIDTH-1:0] wval;

  cell_op_t      op_sel, op;
  logic [PW-1:0] at;
  logic [PW-1:0] rd_pos;
  logic          rd_en;
  logic          moved_next;
  status_t       status_next;

  logic [DATA_WIDTH-1:0] cell_word [CAPACITY];
  logic [DATA_WIDTH-1:0] cell_rd   [CAPACITY];
  logic [DATA_WIDTH-1:0] rd_word;
  logic signed [EW-1:0]  rd_ext;
  logic [31:0]           data_next;

  assign in_stall = out_valid && out_stall;
  assign accept   = in_valid && !in_stall;

  assign empty   = (cnt == '0);
  assign idx_w   = IW'(index);
  assign idx_ok  = idx_w < IW'(cnt);
  assign val_ext = EW'(value);
  assign wval    = val_ext[DATA_WIDTH-1:0];

  always_comb begin
    op_sel      = CELL_HOLD;
    at          = cur;
    rd_pos      = cur;
    rd_en       = 1'b0;
    moved_next  = 1'b0;
    status_next = ST_OK;
    cur_next    = cur;
    cnt_next    = cnt;
    if (empty && (action inside {[ACT_READ_CUR:ACT_DELETE]})) begin
      status_next = ST_EMPTY;
    end else begin
      case (action)
        ACT_READ_CUR: begin
          rd_en = 1'b1;
        end
        ACT_WRITE_CUR: begin
          op_sel = CELL_WRITE;
        end
        ACT_PREV: begin
          if (cur != '0) begin
            cur_next   = cur - PW'(1);
            moved_next = 1'b1;
          end
        end
        ACT_NEXT: begin
          if (CW'(cur) + CW'(1) < cnt) begin
            cur_next   = cur + PW'(1);
            moved_next = 1'b1;
          end
        end
        ACT_FIRST: begin
          cur_next = '0;
        end
        ACT_LAST: begin
          cur_next = PW'(cnt - CW'(1));
        end
        ACT_DELETE: begin
          op_sel   = CELL_DELETE;
          cnt_next = cnt - CW'(1);
          if (cnt == CW'(1)) cur_next = '0;
          else if (CW'(cur) == cnt - CW'(1)) cur_next = cur - PW'(1);
        end
        ACT_INS_BEFORE, ACT_INS_AFTER: begin
          if (cnt == CAP_CNT) begin
            status_next = ST_FULL;
          end else if (empty) begin
            op_sel   = CELL_WRITE;
            at       = '0;
            cur_next = '0;
            cnt_next = CW'(1);
          end else begin
            op_sel   = CELL_INSERT;
            cnt_next = cnt + CW'(1);
            if (action == ACT_INS_BEFORE) cur_next = cur + PW'(1);
            else at = cur + PW'(1);
          end
        end
        ACT_READ_IDX: begin
          rd_pos = idx_w[PW-1:0];
          if (idx_ok) rd_en = 1'b1;
          else status_next = ST_RANGE;
        end
        ACT_WRITE_IDX: begin
          at = idx_w[PW-1:0];
          if (idx_ok) op_sel = CELL_WRITE;
          else status_next = ST_RANGE;
        end
        default: begin
        end
      endcase
    end
  end

  assign op = accept ? op_sel : CELL_HOLD;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [DATA_WIDTH-1:0] lo, hi;
    if (i == 0) begin : g_lo0
      assign lo = '0;
    end else begin : g_lo
      assign lo = cell_word[i-1];
    end
    if (i == CAPACITY - 1) begin : g_hi0
      assign hi = '0;
    end else begin : g_hi
      assign hi = cell_word[i+1];
    end
    cal_cell #(
      .DATA_WIDTH(DATA_WIDTH),
      .POS_W     (PW),
      .POS       (i)
    ) u_cell (
      .clk    (clk),
      .op     (op),
      .at     (at),
      .wdata  (wval),
      .from_lo(lo),
      .from_hi(hi),
      .rd_pos (rd_pos),
      .word   (cell_word[i]),
      .rd_word(cell_rd[i])
    );
  end

  always_comb begin
    rd_word = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      rd_word = rd_word | cell_rd[i];
    end
  end

  assign rd_ext    = EW'(signed'(rd_word));
  assign data_next = rd_en ? rd_ext[31:0] : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt       <= '0;
      cur       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        cnt       <= cnt_next;
        cur       <= cur_next;
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  logic [OW-1:0]  cnt_out;
  logic [PXW-1:0] cur_out;
  assign cnt_out = OW'(cnt_next);
  assign cur_out = PXW'(cur_next);

  always_ff @(posedge clk) begin
    if (accept) begin
      data   <= data_next;
      moved  <= moved_next;
      status <= status_next;
      count  <= cnt_out[6:0];
      cursor <= cur_out[5:0];
    end
  end

endmodule

// File: hw/rtl/cal_checker.sv
// cal_checker: port-level checks for cursor_array_list_unit, bound to the top level
// depends on cal_pkg for status codes
module cal_checker import cal_pkg::*; (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_stall,
  input logic [3:0]         action,
  input logic signed [31:0] value,
  input logic [5:0]         index,
  input logic               out_valid,
  input logic               out_stall,
  input logic signed [31:0] data,
  input logic               moved,
  input logic [1:0]         status,
  input logic [6:0]         count,
  input logic [5:0]         cursor
);

  a_held_blocks: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |-> in_stall)
    else $error("input taken while result held");

  a_empty_count: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_EMPTY |-> count == 7'd0 && cursor == 6'd0)
    else $error("empty status with nonzero count or cursor");

  a_moved_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && moved |-> status == ST_OK)
    else $error("moved flagged on error");

  a_err_data: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_OK |-> data == 32'sd0)
    else $error("nonzero data on error");

  a_beat_out: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> out_valid)
    else $error("accepted beat gave no result");

endmodule

bind cursor_array_list_unit cal_checker u_cal_checker (.*);
